// File: rtl/scancode_set1_key_decoder_fifo_unit_defines.svh
// ----------------------------------------------------------------------------
// Scan-code set 1 decoder: assertion macros
// Clocked assertion shorthands used by the key FIFO RTL.
// ----------------------------------------------------------------------------
`ifndef SCANCODE_SET1_KEY_DECODER_FIFO_UNIT_DEFINES_SVH
`define SCANCODE_SET1_KEY_DECODER_FIFO_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SC1KD_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (pre) |-> (post)) else $error(msg);

// next-cycle implication, checked out of reset
`define SC1KD_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (pre) |=> (post)) else $error(msg);

`endif

// File: rtl/sc1kd_pkg.sv
// ----------------------------------------------------------------------------
// Scan-code set 1 decoder package
// Scan-code constants, special key codes, keymap tables and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package sc1kd_pkg;

    localparam logic [7:0] SC_PREFIX    = 8'hE0;
    localparam logic [7:0] SC_BREAK_BIT = 8'h80;
    localparam logic [6:0] SC_CODE_MASK = 7'h7F;
    localparam logic [6:0] SC_LSHIFT    = 7'h2A;
    localparam logic [6:0] SC_RSHIFT    = 7'h36;
    localparam logic [6:0] SC_CTRL      = 7'h1D;
    localparam logic [7:0] CTRL_MASK    = 8'h1F;

    localparam logic [7:0] SC_EXT_UP    = 8'h48;
    localparam logic [7:0] SC_EXT_DOWN  = 8'h50;
    localparam logic [7:0] SC_EXT_LEFT  = 8'h4B;
    localparam logic [7:0] SC_EXT_RIGHT = 8'h4D;
    localparam logic [7:0] SC_EXT_HOME  = 8'h47;
    localparam logic [7:0] SC_EXT_END   = 8'h4F;
    localparam logic [7:0] SC_EXT_PGUP  = 8'h49;
    localparam logic [7:0] SC_EXT_PGDN  = 8'h51;
    localparam logic [7:0] SC_EXT_DEL   = 8'h53;

    localparam logic [7:0] KEY_NONE     = 8'd0;
    localparam logic [7:0] KC_UP        = 8'd128;
    localparam logic [7:0] KC_DOWN      = 8'd129;
    localparam logic [7:0] KC_LEFT      = 8'd130;
    localparam logic [7:0] KC_RIGHT     = 8'd131;
    localparam logic [7:0] KC_HOME      = 8'd132;
    localparam logic [7:0] KC_END       = 8'd133;
    localparam logic [7:0] KC_PAGE_UP   = 8'd134;
    localparam logic [7:0] KC_PAGE_DOWN = 8'd135;
    localparam logic [7:0] KC_DEL       = 8'd136;

    localparam logic CMD_SCAN = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef struct packed {
        logic queued;
        logic dropped;
        logic popped;
        logic not_empty;
    } t_fifo_status;

    function automatic logic [7:0] f_extended_key(input logic [7:0] code);
        logic [7:0] key;
        case (code)
            SC_EXT_UP:    key = KC_UP;
            SC_EXT_DOWN:  key = KC_DOWN;
            SC_EXT_LEFT:  key = KC_LEFT;
            SC_EXT_RIGHT: key = KC_RIGHT;
            SC_EXT_HOME:  key = KC_HOME;
            SC_EXT_END:   key = KC_END;
            SC_EXT_PGUP:  key = KC_PAGE_UP;
            SC_EXT_PGDN:  key = KC_PAGE_DOWN;
            SC_EXT_DEL:   key = KC_DEL;
            default:      key = KEY_NONE;
        endcase
        return key;
    endfunction

    function automatic logic [7:0] f_plain_map(input logic [6:0] code);
        logic [7:0] key;
        case (code)
            7'd1:  key = 8'h1B;  7'd2:  key = 8'h31;  7'd3:  key = 8'h32;
            7'd4:  key = 8'h33;  7'd5:  key = 8'h34;  7'd6:  key = 8'h35;
            7'd7:  key = 8'h36;  7'd8:  key = 8'h37;  7'd9:  key = 8'h38;
            7'd10: key = 8'h39;  7'd11: key = 8'h30;  7'd12: key = 8'h2D;
            7'd13: key = 8'h3D;  7'd14: key = 8'h08;  7'd15: key = 8'h09;
            7'd16: key = 8'h71;  7'd17: key = 8'h77;  7'd18: key = 8'h65;
            7'd19: key = 8'h72;  7'd20: key = 8'h74;  7'd21: key = 8'h7A;
            7'd22: key = 8'h75;  7'd23: key = 8'h69;  7'd24: key = 8'h6F;
            7'd25: key = 8'h70;  7'd26: key = 8'h5B;  7'd27: key = 8'h2B;
            7'd28: key = 8'h0A;
            7'd30: key = 8'h61;  7'd31: key = 8'h73;  7'd32: key = 8'h64;
            7'd33: key = 8'h66;  7'd34: key = 8'h67;  7'd35: key = 8'h68;
            7'd36: key = 8'h6A;  7'd37: key = 8'h6B;  7'd38: key = 8'h6C;
            7'd39: key = 8'h3B;  7'd40: key = 8'h27;  7'd41: key = 8'h5E;
            7'd43: key = 8'h23;  7'd44: key = 8'h79;  7'd45: key = 8'h78;
            7'd46: key = 8'h63;  7'd47: key = 8'h76;  7'd48: key = 8'h62;
            7'd49: key = 8'h6E;  7'd50: key = 8'h6D;  7'd51: key = 8'h2C;
            7'd52: key = 8'h2E;  7'd53: key = 8'h2D;
            7'd55: key = 8'h2A;  7'd57: key = 8'h20;  7'd74: key = 8'h2D;
            7'd78: key = 8'h2B;  7'd86: key = 8'h3C;
            default: key = KEY_NONE;
        endcase
        return key;
    endfunction

    function automatic logic [7:0] f_shifted_map(input logic [6:0] code);
        logic [7:0] key;
        case (code)
            7'd1:  key = 8'h1B;  7'd2:  key = 8'h21;  7'd3:  key = 8'h22;
            7'd4:  key = 8'h23;  7'd5:  key = 8'h24;  7'd6:  key = 8'h25;
            7'd7:  key = 8'h26;  7'd8:  key = 8'h2F;  7'd9:  key = 8'h28;
            7'd10: key = 8'h29;  7'd11: key = 8'h3D;  7'd12: key = 8'h3F;
            7'd13: key = 8'h60;  7'd14: key = 8'h08;  7'd15: key = 8'h09;
            7'd16: key = 8'h51;  7'd17: key = 8'h57;  7'd18: key = 8'h45;
            7'd19: key = 8'h52;  7'd20: key = 8'h54;  7'd21: key = 8'h5A;
            7'd22: key = 8'h55;  7'd23: key = 8'h49;  7'd24: key = 8'h4F;
            7'd25: key = 8'h50;  7'd26: key = 8'h7B;  7'd27: key = 8'h2A;
            7'd28: key = 8'h0A;
            7'd30: key = 8'h41;  7'd31: key = 8'h53;  7'd32: key = 8'h44;
            7'd33: key = 8'h46;  7'd34: key = 8'h47;  7'd35: key = 8'h48;
            7'd36: key = 8'h4A;  7'd37: key = 8'h4B;  7'd38: key = 8'h4C;
            7'd39: key = 8'h3A;  7'd40: key = 8'h22;  7'd41: key = 8'h7E;
            7'd43: key = 8'h27;  7'd44: key = 8'h59;  7'd45: key = 8'h58;
            7'd46: key = 8'h43;  7'd47: key = 8'h56;  7'd48: key = 8'h42;
            7'd49: key = 8'h4E;  7'd50: key = 8'h4D;  7'd51: key = 8'h3B;
            7'd52: key = 8'h3A;  7'd53: key = 8'h5F;
            7'd55: key = 8'h2A;  7'd57: key = 8'h20;  7'd74: key = 8'h2D;
            7'd78: key = 8'h2B;  7'd86: key = 8'h3E;
            default: key = KEY_NONE;
        endcase
        return key;
    endfunction

endpackage

`default_nettype wire

// File: rtl/sc1kd_in_if.sv
// ----------------------------------------------------------------------------
// Scan-code decoder input channel
// Valid/ready channel carrying one command word: scan byte or pop request.
// ----------------------------------------------------------------------------
`default_nettype none

interface sc1kd_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] scan_byte;

    modport source (output valid, output command, output scan_byte, input ready);
    modport sink   (input valid, input command, input scan_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/sc1kd_out_if.sv
// ----------------------------------------------------------------------------
// Scan-code decoder result channel
// Valid/ready channel carrying one result word per command word.
// ----------------------------------------------------------------------------
`default_nettype none

interface sc1kd_out_if;
    logic       valid;
    logic       ready;
    logic       read_valid;
    logic [7:0] read_key;
    logic       key_queued;
    logic       key_dropped;
    logic       fifo_not_empty;

    modport source (
        output valid, output read_valid, output read_key, output key_queued,
        output key_dropped, output fifo_not_empty, input ready
    );
    modport sink (
        input valid, input read_valid, input read_key, input key_queued,
        input key_dropped, input fifo_not_empty, output ready
    );
endinterface

`default_nettype wire

// File: rtl/sc1kd_decoder.sv
// ----------------------------------------------------------------------------
// Scan-code set 1 byte decoder
// Tracks prefix, shift and ctrl state and maps a byte to a key code.
// ----------------------------------------------------------------------------
`default_nettype none

module sc1kd_decoder (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_en,
    input  wire logic [7:0] i_scan_byte,
    output logic      [7:0] o_key
);
    import sc1kd_pkg::*;

    logic       r_prefix, r_shift, r_ctrl;
    logic       n_prefix, n_shift, n_ctrl;
    logic [6:0] code;
    logic [7:0] map_key;
    logic       is_letter;

    assign code = i_scan_byte[6:0] & SC_CODE_MASK;

    always_comb begin
        map_key   = r_shift ? f_shifted_map(code) : f_plain_map(code);
        is_letter = (map_key >= 8'h61 && map_key <= 8'h7A) ||
                    (map_key >= 8'h41 && map_key <= 8'h5A);
    end

    always_comb begin
        n_prefix = r_prefix;
        n_shift  = r_shift;
        n_ctrl   = r_ctrl;
        o_key    = KEY_NONE;
        if (i_scan_byte == SC_PREFIX) begin
            n_prefix = 1'b1;
        end else if (r_prefix) begin
            n_prefix = 1'b0;
            if ((i_scan_byte & SC_BREAK_BIT) == 8'h00) begin
                o_key = f_extended_key(i_scan_byte);
            end
        end else if ((i_scan_byte & SC_BREAK_BIT) != 8'h00) begin
            if (code == SC_LSHIFT || code == SC_RSHIFT) begin
                n_shift = 1'b0;
            end
            if (code == SC_CTRL) begin
                n_ctrl = 1'b0;
            end
        end else if (code == SC_LSHIFT || code == SC_RSHIFT) begin
            n_shift = 1'b1;
        end else if (code == SC_CTRL) begin
            n_ctrl = 1'b1;
        end else if (r_ctrl && is_letter) begin
            o_key = map_key & CTRL_MASK;
        end else begin
            o_key = map_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix <= 1'b0;
            r_shift  <= 1'b0;
            r_ctrl   <= 1'b0;
        end else if (i_en) begin
            r_prefix <= n_prefix;
            r_shift  <= n_shift;
            r_ctrl   <= n_ctrl;
        end
    end

endmodule

`default_nettype wire

// File: rtl/sc1kd_fifo.sv
// ----------------------------------------------------------------------------
// Key FIFO
// Ring buffer of key codes with drop-on-full push and non-blocking pop.
// ----------------------------------------------------------------------------
`default_nettype none

`include "scancode_set1_key_decoder_fifo_unit_defines.svh"

module sc1kd_fifo #(
    parameter int FIFO_DEPTH = 64
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire logic                    i_push,
    input  wire logic [7:0]              i_push_key,
    input  wire logic                    i_pop,
    output sc1kd_pkg::t_fifo_status      o_status,
    output logic      [7:0]              o_rd_key
);
    import sc1kd_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 2) ? $clog2(FIFO_DEPTH) : 1;
    localparam logic [PTR_W-1:0] LAST = PTR_W'(FIFO_DEPTH - 1);

    logic [7:0]       mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [PTR_W-1:0] n_wr_ptr, n_rd_ptr;
    logic [PTR_W-1:0] wr_inc, rd_inc;
    logic             full, empty, do_push, do_pop;

    assign wr_inc  = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
    assign rd_inc  = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
    assign full    = (wr_inc == r_rd_ptr);
    assign empty   = (r_wr_ptr == r_rd_ptr);
    assign do_push = i_push && !full;
    assign do_pop  = i_pop && !empty;

    always_comb begin
        n_wr_ptr = do_push ? wr_inc : r_wr_ptr;
        n_rd_ptr = do_pop ? rd_inc : r_rd_ptr;
        o_status.queued    = do_push;
        o_status.dropped   = i_push && full;
        o_status.popped    = do_pop;
        o_status.not_empty = (n_wr_ptr != n_rd_ptr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else if (i_en) begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && do_push) begin
            mem[r_wr_ptr] <= i_push_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rd_key <= do_pop ? mem[r_rd_ptr] : KEY_NONE;
        end
    end

    `SC1KD_ASSERT_NEXT(a_full_holds_wr, i_en && i_push && full, $stable(r_wr_ptr), "push into full FIFO moved write pointer")
    `SC1KD_ASSERT_NEXT(a_empty_holds_rd, i_en && i_pop && empty, $stable(r_rd_ptr), "pop on empty FIFO moved read pointer")
    `SC1KD_ASSERT_NEXT(a_push_not_empty, i_en && do_push, r_wr_ptr != r_rd_ptr, "accepted push left FIFO empty")
    `SC1KD_ASSERT_NOW(a_one_access, i_en, !(do_push && do_pop), "push and pop in one step")

endmodule

`default_nettype wire

// File: rtl/scancode_set1_key_decoder_fifo_unit.sv
// ----------------------------------------------------------------------------
// Scan-code set 1 key decoder with key FIFO
// Top level: input register, byte decoder, key FIFO and result register.
// ----------------------------------------------------------------------------
// Usage:
//   i_item carries one command word: command 0 delivers a raw set 1 scan
//   byte, command 1 pops one key from the FIFO. Every command word yields
//   exactly one result word on o_result, in order.
//   A scan byte result reports whether a key was queued or dropped (full
//   FIFO); a pop result returns the key with read_valid, or read_valid 0
//   when the FIFO is empty. fifo_not_empty reflects the state after the word.
//   A word passes through the input register and then the result register.
//   Throughput: one word per cycle while the receiver takes results; the
//   decode, the keymap lookup and one FIFO memory access fit between the
//   input and result registers. The FIFO holds FIFO_DEPTH-1 keys.
//   Reset clears the FIFO pointers, the prefix, shift and ctrl flags and
//   the valid flags of both register stages; FIFO contents are not cleared.
//   When the receiver stalls, the result word holds, the input register
//   takes one more word, then i_item.ready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module scancode_set1_key_decoder_fifo_unit #(
    parameter int FIFO_DEPTH = 64
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sc1kd_in_if.sink    i_item,
    sc1kd_out_if.source o_result
);
    import sc1kd_pkg::*;

    logic         r_in_valid;
    logic         r_in_cmd;
    logic [7:0]   r_in_byte;
    logic         r_out_valid;
    logic         r_read_valid;
    logic         r_key_queued;
    logic         r_key_dropped;
    logic         r_not_empty;
    logic         advance;
    logic         dec_en;
    logic [7:0]   dec_key;
    logic [7:0]   rd_key;
    t_fifo_status fifo_status;

    assign advance      = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || advance;
    assign dec_en       = advance && (r_in_cmd == CMD_SCAN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in_cmd  <= i_item.command;
            r_in_byte <= i_item.scan_byte;
        end
    end

    sc1kd_decoder u_decoder (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (dec_en),
        .i_scan_byte (r_in_byte),
        .o_key       (dec_key)
    );

    sc1kd_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (advance),
        .i_push     ((r_in_cmd == CMD_SCAN) && (dec_key != KEY_NONE)),
        .i_push_key (dec_key),
        .i_pop      (r_in_cmd == CMD_POP),
        .o_status   (fifo_status),
        .o_rd_key   (rd_key)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_read_valid  <= fifo_status.popped;
            r_key_queued  <= fifo_status.queued;
            r_key_dropped <= fifo_status.dropped;
            r_not_empty   <= fifo_status.not_empty;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.read_valid     = r_read_valid;
    assign o_result.read_key       = rd_key;
    assign o_result.key_queued     = r_key_queued;
    assign o_result.key_dropped    = r_key_dropped;
    assign o_result.fifo_not_empty = r_not_empty;

endmodule

`default_nettype wire

// File: bench/tb_scancode_set1_key_decoder_fifo_unit.sv
// ----------------------------------------------------------------------------
// Testbench: scan-code set 1 key decoder with key FIFO
// Feeds scan bytes and pop requests through the valid/ready channels, with
// random gaps and stalls on both sides. Each result word is compared with a
// local decoder and key queue, or with a directed row's own expected word.
// Directed words come first, then random typing, fill and drain traffic.
// ----------------------------------------------------------------------------
module tb_scancode_set1_key_decoder_fifo_unit;

    import sc1kd_pkg::*;

    localparam int KEY_FIFO_DEPTH = 64;
    localparam int RANDOM_WORDS   = 600;

    typedef struct packed {
        logic       read_valid;
        logic [7:0] read_key;
        logic       key_queued;
        logic       key_dropped;
        logic       fifo_not_empty;
    } key_result_t;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  code;
        logic        has_exp;
        key_result_t exp;
    } dir_row_t;

    typedef struct {
        logic        cmd;
        logic [7:0]  code;
        bit          hold;
        bit          calm;
        bit          has_exp;
        key_result_t exp;
    } plan_word_t;

    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_t;

    localparam key_result_t NOTHING      = '{1'b0, KEY_NONE, 1'b0, 1'b0, 1'b0};
    localparam key_result_t QUEUED_FIRST = '{1'b0, KEY_NONE, 1'b1, 1'b0, 1'b1};

    localparam logic [7:0] LSHIFT_MAKE  = {1'b0, SC_LSHIFT};
    localparam logic [7:0] RSHIFT_MAKE  = {1'b0, SC_RSHIFT};
    localparam logic [7:0] CTRL_MAKE    = {1'b0, SC_CTRL};
    localparam logic [7:0] LSHIFT_BREAK = SC_BREAK_BIT | LSHIFT_MAKE;
    localparam logic [7:0] RSHIFT_BREAK = SC_BREAK_BIT | RSHIFT_MAKE;
    localparam logic [7:0] CTRL_BREAK   = SC_BREAK_BIT | CTRL_MAKE;

    localparam logic [7:0] EXT_CODES [9] = '{
        SC_EXT_UP, SC_EXT_DOWN, SC_EXT_LEFT, SC_EXT_RIGHT, SC_EXT_HOME,
        SC_EXT_END, SC_EXT_PGUP, SC_EXT_PGDN, SC_EXT_DEL
    };

    localparam int DIR_ROWS = 30;
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{CMD_POP,  8'h00,        1'b1, NOTHING},
        '{CMD_SCAN, 8'h00,        1'b1, NOTHING},
        '{CMD_SCAN, 8'hFF,        1'b1, NOTHING},
        '{CMD_SCAN, 8'h1E,        1'b1, QUEUED_FIRST},
        '{CMD_SCAN, LSHIFT_MAKE,  1'b0, NOTHING},
        '{CMD_SCAN, 8'h1E,        1'b0, NOTHING},
        '{CMD_SCAN, LSHIFT_BREAK, 1'b0, NOTHING},
        '{CMD_SCAN, RSHIFT_MAKE,  1'b0, NOTHING},
        '{CMD_SCAN, 8'h02,        1'b0, NOTHING},
        '{CMD_SCAN, 8'h56,        1'b0, NOTHING},
        '{CMD_SCAN, RSHIFT_BREAK, 1'b0, NOTHING},
        '{CMD_SCAN, CTRL_MAKE,    1'b0, NOTHING},
        '{CMD_SCAN, 8'h1E,        1'b0, NOTHING},
        '{CMD_SCAN, 8'h02,        1'b0, NOTHING},
        '{CMD_SCAN, CTRL_BREAK,   1'b0, NOTHING},
        '{CMD_SCAN, SC_PREFIX,    1'b0, NOTHING},
        '{CMD_SCAN, SC_PREFIX,    1'b0, NOTHING},
        '{CMD_SCAN, SC_EXT_UP,    1'b0, NOTHING},
        '{CMD_SCAN, SC_PREFIX,    1'b0, NOTHING},
        '{CMD_SCAN, 8'hC8,        1'b0, NOTHING},
        '{CMD_SCAN, SC_PREFIX,    1'b0, NOTHING},
        '{CMD_SCAN, LSHIFT_MAKE,  1'b0, NOTHING},
        '{CMD_SCAN, 8'h1E,        1'b0, NOTHING},
        '{CMD_SCAN, SC_PREFIX,    1'b0, NOTHING},
        '{CMD_SCAN, SC_EXT_DEL,   1'b0, NOTHING},
        '{CMD_SCAN, SC_PREFIX,    1'b0, NOTHING},
        '{CMD_SCAN, 8'h10,        1'b0, NOTHING},
        '{CMD_SCAN, 8'h7F,        1'b0, NOTHING},
        '{CMD_POP,  8'hFF,        1'b0, NOTHING},
        '{CMD_POP,  8'h00,        1'b0, NOTHING}
    };

    logic i_clk;
    logic i_rst_n;

    sc1kd_in_if  in_if ();
    sc1kd_out_if out_if ();

    scancode_set1_key_decoder_fifo_unit #(
        .FIFO_DEPTH(KEY_FIFO_DEPTH)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (in_if),
        .o_result(out_if)
    );

    logic [7:0]  held_keys [$];
    logic        shift_on;
    logic        ctrl_on;
    logic        ext_armed;
    key_result_t expected_results [$];
    plan_word_t  word_plan [$];
    bit          calm;
    int          mismatches;

    function automatic logic [7:0] keymap_lookup(input logic shifted, input logic [6:0] code);
        string digits, top, home, bottom;
        int    c;
        c = code;
        if (shifted) begin
            digits = "!\"#$%&/()=?";
            top    = "QWERTZUIOP{*";
            home   = "ASDFGHJKL:\"~";
            bottom = "'YXCVBNM;:_";
        end else begin
            digits = "1234567890-";
            top    = "qwertzuiop[+";
            home   = "asdfghjkl;'^";
            bottom = "#yxcvbnm,.-";
        end
        if (c >= 2 && c <= 12) return digits[c - 2];
        if (c >= 16 && c <= 27) return top[c - 16];
        if (c >= 30 && c <= 41) return home[c - 30];
        if (c >= 43 && c <= 53) return bottom[c - 43];
        case (c)
            1:  return 8'h1B;
            13: return shifted ? 8'h60 : "=";
            14: return 8'h08;
            15: return 8'h09;
            28: return 8'h0A;
            55: return "*";
            57: return " ";
            74: return "-";
            78: return "+";
            86: return shifted ? ">" : "<";
            default: return KEY_NONE;
        endcase
    endfunction

    function automatic key_result_t decode_word(input logic cmd, input logic [7:0] code);
        key_result_t res;
        logic [7:0]  key;
        res = NOTHING;
        key = KEY_NONE;
        if (cmd == CMD_POP) begin
            if (held_keys.size() != 0) begin
                res.read_valid = 1'b1;
                res.read_key   = held_keys.pop_front();
            end
        end else begin
            if (code == SC_PREFIX) begin
                ext_armed = 1'b1;
            end else if (ext_armed) begin
                ext_armed = 1'b0;
                if (!code[7]) begin
                    case (code)
                        SC_EXT_UP:    key = KC_UP;
                        SC_EXT_DOWN:  key = KC_DOWN;
                        SC_EXT_LEFT:  key = KC_LEFT;
                        SC_EXT_RIGHT: key = KC_RIGHT;
                        SC_EXT_HOME:  key = KC_HOME;
                        SC_EXT_END:   key = KC_END;
                        SC_EXT_PGUP:  key = KC_PAGE_UP;
                        SC_EXT_PGDN:  key = KC_PAGE_DOWN;
                        SC_EXT_DEL:   key = KC_DEL;
                        default:      key = KEY_NONE;
                    endcase
                end
            end else if (code[7]) begin
                if (code[6:0] == SC_LSHIFT || code[6:0] == SC_RSHIFT) shift_on = 1'b0;
                if (code[6:0] == SC_CTRL) ctrl_on = 1'b0;
            end else if (code[6:0] == SC_LSHIFT || code[6:0] == SC_RSHIFT) begin
                shift_on = 1'b1;
            end else if (code[6:0] == SC_CTRL) begin
                ctrl_on = 1'b1;
            end else begin
                key = keymap_lookup(shift_on, code[6:0]);
                if (ctrl_on && ((key >= "a" && key <= "z") || (key >= "A" && key <= "Z")))
                    key = key & CTRL_MASK;
            end
            if (key != KEY_NONE) begin
                if (held_keys.size() < KEY_FIFO_DEPTH - 1) begin
                    held_keys.push_back(key);
                    res.key_queued = 1'b1;
                end else begin
                    res.key_dropped = 1'b1;
                end
            end
        end
        res.fifo_not_empty = (held_keys.size() != 0);
        return res;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    task automatic plan_word(input logic cmd, input logic [7:0] code, input bit hold,
                             input bit quiet);
        plan_word_t w;
        w.cmd     = cmd;
        w.code    = code;
        w.hold    = hold;
        w.calm    = quiet;
        w.has_exp = 1'b0;
        w.exp     = NOTHING;
        word_plan.push_back(w);
    endtask

    task automatic build_random_plan();
        traffic_mode_t mode;
        int            seg_len, pop_pct, r, k;
        bit            seg_hold, seg_calm, first, h;
        logic [7:0]    ext;
        first = 1'b1;
        while (word_plan.size() < DIR_ROWS + RANDOM_WORDS) begin
            mode     = first ? MODE_FILL : traffic_mode_t'($urandom_range(2));
            seg_len  = first ? 130 : $urandom_range(110, 20);
            seg_hold = first || ($urandom_range(3) == 0);
            seg_calm = !first && ($urandom_range(4) == 0);
            pop_pct  = (mode == MODE_FILL) ? 5 : (mode == MODE_DRAIN) ? 80 : 45;
            for (k = 0; k < seg_len; k++) begin
                h = seg_hold && (k == 0);
                r = $urandom_range(99);
                if ($urandom_range(99) < pop_pct) begin
                    plan_word(CMD_POP, 8'($urandom_range(255)), h, seg_calm);
                end else if (r < 55) begin
                    if (mode == MODE_FILL)
                        plan_word(CMD_SCAN, 8'($urandom_range(53, 16)), h, seg_calm);
                    else
                        plan_word(CMD_SCAN, 8'($urandom_range(86, 1)), h, seg_calm);
                end else if (r < 63) begin
                    case ($urandom_range(3))
                        0: plan_word(CMD_SCAN, LSHIFT_MAKE, h, seg_calm);
                        1: plan_word(CMD_SCAN, RSHIFT_MAKE, h, seg_calm);
                        2: plan_word(CMD_SCAN, LSHIFT_BREAK, h, seg_calm);
                        default: plan_word(CMD_SCAN, RSHIFT_BREAK, h, seg_calm);
                    endcase
                end else if (r < 69) begin
                    plan_word(CMD_SCAN, $urandom_range(1) ? CTRL_MAKE : CTRL_BREAK, h, seg_calm);
                end else if (r < 81) begin
                    plan_word(CMD_SCAN, SC_PREFIX, h, seg_calm);
                    ext = EXT_CODES[$urandom_range(8)];
                    case ($urandom_range(3))
                        0, 1: plan_word(CMD_SCAN, ext, 1'b0, seg_calm);
                        2: plan_word(CMD_SCAN, ext | SC_BREAK_BIT, 1'b0, seg_calm);
                        default: plan_word(CMD_SCAN, 8'($urandom_range(255)), 1'b0, seg_calm);
                    endcase
                end else if (r < 88) begin
                    plan_word(CMD_SCAN, {1'b1, 7'($urandom_range(127))}, h, seg_calm);
                end else begin
                    plan_word(CMD_SCAN, 8'($urandom_range(255)), h, seg_calm);
                end
            end
            first = 1'b0;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // sender: walk the plan, predict each word as it is accepted
    initial begin
        plan_word_t  w;
        key_result_t exp;
        int          gap;
        i_rst_n         = 1'b0;
        in_if.valid     = 1'b0;
        in_if.command   = CMD_SCAN;
        in_if.scan_byte = 8'h00;
        shift_on        = 1'b0;
        ctrl_on         = 1'b0;
        ext_armed       = 1'b0;
        calm            = 1'b0;
        mismatches      = 0;
        for (int n = 0; n < DIR_ROWS; n++) begin
            w.cmd     = DIR_TABLE[n].cmd;
            w.code    = DIR_TABLE[n].code;
            w.hold    = 1'b0;
            w.calm    = 1'b0;
            w.has_exp = DIR_TABLE[n].has_exp;
            w.exp     = DIR_TABLE[n].exp;
            word_plan.push_back(w);
        end
        build_random_plan();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int n = 0; n < word_plan.size(); n++) begin
            w = word_plan[n];
            if (w.hold) begin
                @(negedge i_clk);
                in_if.valid <= 1'b0;
                while (expected_results.size() != 0) @(posedge i_clk);
            end
            calm = w.calm;
            gap  = w.calm ? 0 : gap_len();
            @(negedge i_clk);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            in_if.valid     <= 1'b1;
            in_if.command   <= w.cmd;
            in_if.scan_byte <= w.code;
            do @(posedge i_clk); while (!in_if.ready);
            exp = decode_word(w.cmd, w.code);
            if (w.has_exp) exp = w.exp;
            expected_results.push_back(exp);
        end
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // receiver: random stalls, none in calm stretches
    initial begin
        int stall_left;
        stall_left   = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else begin
                out_if.ready <= 1'b1;
                if (!calm) stall_left = gap_len();
            end
        end
    end

    always @(posedge i_clk) begin
        key_result_t got, exp;
        if (i_rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            got = '{out_if.read_valid, out_if.read_key, out_if.key_queued,
                    out_if.key_dropped, out_if.fifo_not_empty};
            if (expected_results.size() == 0) begin
                mismatches++;
                $display("%0t: result word with no word pending: rv=%b key=%h q=%b d=%b ne=%b",
                         $time, got.read_valid, got.read_key, got.key_queued,
                         got.key_dropped, got.fifo_not_empty);
            end else begin
                exp = expected_results.pop_front();
                if (got !== exp) begin
                    mismatches++;
                    $display({"%0t: mismatch expected rv=%b key=%h q=%b d=%b ne=%b,",
                              " actual rv=%b key=%h q=%b d=%b ne=%b"},
                             $time, exp.read_valid, exp.read_key, exp.key_queued,
                             exp.key_dropped, exp.fifo_not_empty, got.read_valid,
                             got.read_key, got.key_queued, got.key_dropped,
                             got.fifo_not_empty);
                end
            end
        end
    end

endmodule
